// File: rtl/els_pkg.sv
// ----------------------------------------------------------------------------
// els_pkg
// Shared types and constants for the LOOK elevator request scheduler.
// ----------------------------------------------------------------------------
package els_pkg;

   localparam int NUM_FLOORS  = 64;
   localparam int MAP_WIDTH   = 64;
   localparam int FLOOR_W     = 6;
   localparam int GROUP_W     = 8;
   localparam int GROUPS      = MAP_WIDTH / GROUP_W;
   localparam int GRP_SEL_W   = $clog2(GROUPS);
   localparam int GRP_IDX_W   = $clog2(GROUP_W);
   localparam int COUNT_W     = 8;
   localparam int FLOOR_LIMIT = (NUM_FLOORS < MAP_WIDTH) ? NUM_FLOORS : MAP_WIDTH;

   typedef enum logic [2:0] {
      EV_QUEUED = 3'd0,
      EV_DOOR   = 3'd1,
      EV_MOVE   = 3'd2,
      EV_IDLE   = 3'd3,
      EV_REJECT = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      DIR_IDLE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SELECT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic select;
   } cmd_type;

   typedef struct packed {
      logic needs_select;
   } status_type;

endpackage

// File: rtl/els_ctrl.sv
// ----------------------------------------------------------------------------
// els_ctrl
// Sequencer: loads a transaction, evaluates it, runs the bitmap search for
// dispatches, then presents the result for one cycle.
// ----------------------------------------------------------------------------
module els_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_strobe,
   output els_pkg::cmd_type    cmd,
   input  els_pkg::status_type status
);

   els_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= els_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         els_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = els_pkg::ST_EVAL;
            end
         end
         els_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.needs_select ? els_pkg::ST_SELECT : els_pkg::ST_RESP;
         end
         els_pkg::ST_SELECT: begin
            cmd.select = 1'b1;
            state_in   = els_pkg::ST_RESP;
         end
         els_pkg::ST_RESP: begin
            rsp_strobe = 1'b1;
            state_in   = els_pkg::ST_IDLE;
         end
         default: begin
            state_in = els_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/els_datapath.sv
// ----------------------------------------------------------------------------
// els_datapath
// Request bitmaps, car position, direction, pending counter and the
// two-level (bit within each group, then group) nearest-request search.
// ----------------------------------------------------------------------------
module els_datapath #(
   parameter int NUM_FLOORS = els_pkg::NUM_FLOORS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  els_pkg::cmd_type                cmd,
   output els_pkg::status_type             status,
   input  logic                            req_kind,
   input  logic [7:0]                      req_floor,
   output logic [2:0]                      rsp_event_res,
   output logic [els_pkg::FLOOR_W-1:0]     rsp_target_floor,
   output logic [1:0]                      rsp_travel_direction,
   output logic [els_pkg::COUNT_W-1:0]     rsp_pending_count
);

   localparam int GW = els_pkg::GROUP_W;
   localparam int NG = els_pkg::GROUPS;
   localparam int IW = els_pkg::GRP_IDX_W;
   localparam int SW = els_pkg::GRP_SEL_W;
   localparam int FL = (NUM_FLOORS < els_pkg::MAP_WIDTH) ? NUM_FLOORS : els_pkg::MAP_WIDTH;

   logic                               kind_ff;
   logic [7:0]                         floor_ff;
   logic [els_pkg::MAP_WIDTH-1:0]      up_ff, up_in;
   logic [els_pkg::MAP_WIDTH-1:0]      down_ff, down_in;
   logic [els_pkg::FLOOR_W-1:0]        cur_ff, cur_in;
   els_pkg::dir_type                   dir_ff, dir_in;
   logic [els_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic                               take_up_ff, take_up_in;
   logic [NG-1:0]                      grp_any_ff, grp_any_in;
   logic [NG-1:0][IW-1:0]              grp_idx_ff, grp_idx_in;
   els_pkg::event_type                 ev_ff, ev_in;
   logic [els_pkg::FLOOR_W-1:0]        tgt_ff, tgt_in;

   logic                               up_any, down_any;
   logic [els_pkg::FLOOR_W-1:0]        floor6;
   logic [els_pkg::MAP_WIDTH-1:0]      sel_map;
   logic [SW-1:0]                      grp_pick;
   logic [els_pkg::FLOOR_W-1:0]        found;

   function automatic logic [IW-1:0] lowest_bit(input logic [GW-1:0] v);
      logic [IW-1:0] r;
      r = '0;
      for (int i = GW - 1; i >= 0; i--) begin
         if (v[i]) r = IW'(i);
      end
      return r;
   endfunction

   function automatic logic [IW-1:0] highest_bit(input logic [GW-1:0] v);
      logic [IW-1:0] r;
      r = '0;
      for (int i = 0; i < GW; i++) begin
         if (v[i]) r = IW'(i);
      end
      return r;
   endfunction

   assign up_any              = |up_ff;
   assign down_any            = |down_ff;
   assign floor6              = floor_ff[els_pkg::FLOOR_W-1:0];
   assign status.needs_select = kind_ff & (up_any | down_any);

   always_comb begin
      grp_pick = '0;
      if (take_up_ff) begin
         for (int g = NG - 1; g >= 0; g--) begin
            if (grp_any_ff[g]) grp_pick = SW'(g);
         end
      end else begin
         for (int g = 0; g < NG; g++) begin
            if (grp_any_ff[g]) grp_pick = SW'(g);
         end
      end
      found = {grp_pick, grp_idx_ff[grp_pick]};
   end

   always_comb begin
      up_in      = up_ff;
      down_in    = down_ff;
      cur_in     = cur_ff;
      dir_in     = dir_ff;
      count_in   = count_ff;
      take_up_in = take_up_ff;
      grp_any_in = grp_any_ff;
      grp_idx_in = grp_idx_ff;
      ev_in      = ev_ff;
      tgt_in     = tgt_ff;
      sel_map    = '0;

      if (cmd.eval) begin
         tgt_in = cur_ff;
         if (!kind_ff) begin
            if (floor_ff >= 8'(FL)) begin
               ev_in = els_pkg::EV_REJECT;
            end else if (floor6 == cur_ff) begin
               ev_in = els_pkg::EV_DOOR;
            end else if (floor6 < cur_ff) begin
               ev_in            = els_pkg::EV_QUEUED;
               down_in[floor6]  = 1'b1;
               if (!down_ff[floor6]) count_in = count_ff + els_pkg::COUNT_W'(1);
            end else begin
               ev_in          = els_pkg::EV_QUEUED;
               up_in[floor6]  = 1'b1;
               if (!up_ff[floor6]) count_in = count_ff + els_pkg::COUNT_W'(1);
            end
         end else if (!up_any && !down_any) begin
            ev_in = els_pkg::EV_IDLE;
         end else begin
            ev_in = els_pkg::EV_MOVE;
            case (dir_ff)
               els_pkg::DIR_UP: begin
                  take_up_in = up_any;
                  dir_in     = up_any ? els_pkg::DIR_UP : els_pkg::DIR_DOWN;
               end
               els_pkg::DIR_DOWN: begin
                  take_up_in = !down_any;
                  dir_in     = down_any ? els_pkg::DIR_DOWN : els_pkg::DIR_UP;
               end
               default: begin
                  take_up_in = up_any;
                  dir_in     = up_any ? els_pkg::DIR_UP : els_pkg::DIR_DOWN;
               end
            endcase
            sel_map = take_up_in ? up_ff : down_ff;
            for (int g = 0; g < NG; g++) begin
               grp_any_in[g] = |sel_map[g*GW +: GW];
               grp_idx_in[g] = take_up_in ? lowest_bit(sel_map[g*GW +: GW])
                                          : highest_bit(sel_map[g*GW +: GW]);
            end
         end
      end

      if (cmd.select) begin
         if (take_up_ff) begin
            up_in[found] = 1'b0;
         end else begin
            down_in[found] = 1'b0;
         end
         cur_in   = found;
         tgt_in   = found;
         count_in = count_ff - els_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff    <= '0;
         down_ff  <= '0;
         cur_ff   <= '0;
         dir_ff   <= els_pkg::DIR_IDLE;
         count_ff <= '0;
      end else begin
         up_ff    <= up_in;
         down_ff  <= down_in;
         cur_ff   <= cur_in;
         dir_ff   <= dir_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         floor_ff <= req_floor;
      end
      take_up_ff <= take_up_in;
      grp_any_ff <= grp_any_in;
      grp_idx_ff <= grp_idx_in;
      ev_ff      <= ev_in;
      tgt_ff     <= tgt_in;
   end

   assign rsp_event_res        = ev_ff;
   assign rsp_target_floor     = tgt_ff;
   assign rsp_travel_direction = dir_ff;
   assign rsp_pending_count    = count_ff;

endmodule

// File: rtl/elevator_look_scheduler.sv
// ----------------------------------------------------------------------------
// elevator_look_scheduler
// LOOK elevator request scheduler: floor requests and dispatch commands in,
// one result transaction out per command.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Its result
// appears on the rsp_ ports for exactly one cycle with rsp_strobe high and
// cannot be held off; capture it in that cycle. A floor request, and a
// dispatch with nothing pending, go through evaluate and respond before the
// next acceptance; a dispatch that finds a pending request also goes through
// select, the second level of the nearest-request search: evaluate scans the
// 64-bit bitmap as eight 8-bit groups, then select picks the group.
module elevator_look_scheduler #(
   parameter int NUM_FLOORS = els_pkg::NUM_FLOORS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_kind,
   input  logic [7:0]                      req_floor,
   output logic                            rsp_strobe,
   output logic [2:0]                      rsp_event_res,
   output logic [els_pkg::FLOOR_W-1:0]     rsp_target_floor,
   output logic [1:0]                      rsp_travel_direction,
   output logic [els_pkg::COUNT_W-1:0]     rsp_pending_count
);

   els_pkg::cmd_type    cmd;
   els_pkg::status_type status;

   els_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   els_datapath #(
      .NUM_FLOORS (NUM_FLOORS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_kind             (req_kind),
      .req_floor            (req_floor),
      .rsp_event_res        (rsp_event_res),
      .rsp_target_floor     (rsp_target_floor),
      .rsp_travel_direction (rsp_travel_direction),
      .rsp_pending_count    (rsp_pending_count)
   );

endmodule
